// ----- rtl/pctd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pctd_pkg;

  localparam int unsigned CharWidth = 8;
  localparam int unsigned NibWidth  = 4;

  localparam logic [CharWidth-1:0] CharPercent = 8'h25;
  localparam logic [CharWidth-1:0] CharDash    = 8'h2D;
  localparam logic [CharWidth-1:0] CharDot     = 8'h2E;
  localparam logic [CharWidth-1:0] CharUnder   = 8'h5F;
  localparam logic [CharWidth-1:0] CharTilde   = 8'h7E;
  localparam logic [CharWidth-1:0] Char0       = 8'h30;
  localparam logic [CharWidth-1:0] Char9       = 8'h39;
  localparam logic [CharWidth-1:0] CharUpA     = 8'h41;
  localparam logic [CharWidth-1:0] CharUpF     = 8'h46;
  localparam logic [CharWidth-1:0] CharUpZ     = 8'h5A;
  localparam logic [CharWidth-1:0] CharLoA     = 8'h61;
  localparam logic [CharWidth-1:0] CharLoZ     = 8'h7A;
  localparam logic [CharWidth-1:0] HexAlphaBase = 8'd10;

  typedef struct packed {
    logic [CharWidth-1:0] char_in;
    logic                 is_last;
  } item_t;

  typedef struct packed {
    logic [CharWidth-1:0] byte_out;
    logic                 byte_valid;
    logic                 string_end;
    logic                 decode_error;
  } result_t;

  function automatic logic is_unreserved(input logic [CharWidth-1:0] c);
    logic r;
    r = ((c >= Char0) && (c <= Char9)) ||
        ((c >= CharUpA) && (c <= CharUpZ)) ||
        ((c >= CharLoA) && (c <= CharLoZ)) ||
        (c == CharDash) || (c == CharDot) || (c == CharUnder) || (c == CharTilde);
    return r;
  endfunction

  // upper-case hex digit only; hit low means not a digit
  function automatic logic is_hex(input logic [CharWidth-1:0] c);
    logic r;
    r = ((c >= Char0) && (c <= Char9)) || ((c >= CharUpA) && (c <= CharUpF));
    return r;
  endfunction

  function automatic logic [NibWidth-1:0] hex_nibble(input logic [CharWidth-1:0] c);
    logic [CharWidth-1:0] v;
    if ((c >= Char0) && (c <= Char9)) begin
      v = c - Char0;
    end else begin
      v = c - CharUpA + HexAlphaBase;
    end
    return v[NibWidth-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/pctd_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface pctd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       is_last;

  modport source (output valid, output char_in, output is_last, input ready);
  modport sink   (input valid, input char_in, input is_last, output ready);
endinterface

`default_nettype wire

// ----- rtl/pctd_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface pctd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_out;
  logic       byte_valid;
  logic       string_end;
  logic       decode_error;

  modport source (output valid, output byte_out, output byte_valid, output string_end,
                  output decode_error, input ready);
  modport sink   (input valid, input byte_out, input byte_valid, input string_end,
                  input decode_error, output ready);
endinterface

`default_nettype wire

// ----- rtl/pctd_in_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pctd_in_stage (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  output logic                ready_o,
  input  wire pctd_pkg::item_t item_i,
  output logic                valid_o,
  input  wire logic           ready_i,
  output pctd_pkg::item_t     item_o
);

  logic            valid_q, valid_d;
  pctd_pkg::item_t item_q, item_d;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (ready_o) begin
      valid_d = valid_i;
      item_d  = item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

// ----- rtl/pctd_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pctd_core (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  output logic                 ready_o,
  input  wire pctd_pkg::item_t item_i,
  output logic                 valid_o,
  input  wire logic            ready_i,
  output pctd_pkg::result_t    result_o
);

  localparam logic [1:0] PhasePlain  = 2'd0;
  localparam logic [1:0] PhaseFirst  = 2'd1;
  localparam logic [1:0] PhaseSecond = 2'd2;

  logic [1:0]                  phase_q, phase_d;
  logic [pctd_pkg::NibWidth-1:0] nib_q, nib_d;
  logic                        failed_q, failed_d;
  logic                        out_valid_q, out_valid_d;
  pctd_pkg::result_t           res_q, res_d;
  logic                        adv;

  logic [1:0]                  ph_n;
  logic [pctd_pkg::NibWidth-1:0] nib_n;
  logic                        fail_n;
  logic [pctd_pkg::CharWidth-1:0] byte_n;
  logic                        bvalid_n;

  assign ready_o = !out_valid_q || ready_i;
  assign adv     = valid_i && ready_o;

  // escape decode for the item at the input register
  always_comb begin
    ph_n     = phase_q;
    nib_n    = nib_q;
    fail_n   = failed_q;
    byte_n   = '0;
    bvalid_n = 1'b0;
    if (!failed_q) begin
      case (phase_q)
        PhaseFirst: begin
          if (pctd_pkg::is_hex(item_i.char_in)) begin
            nib_n = pctd_pkg::hex_nibble(item_i.char_in);
            ph_n  = PhaseSecond;
          end else begin
            fail_n = 1'b1;
          end
        end
        PhaseSecond: begin
          if (pctd_pkg::is_hex(item_i.char_in)) begin
            byte_n   = {nib_q, pctd_pkg::hex_nibble(item_i.char_in)};
            bvalid_n = 1'b1;
            ph_n     = PhasePlain;
          end else begin
            fail_n = 1'b1;
          end
        end
        default: begin
          ph_n = PhasePlain;
          if (pctd_pkg::is_unreserved(item_i.char_in)) begin
            byte_n   = item_i.char_in;
            bvalid_n = 1'b1;
          end else if (item_i.char_in == pctd_pkg::CharPercent) begin
            ph_n = PhaseFirst;
          end else begin
            fail_n = 1'b1;
          end
        end
      endcase
      // escape cut off by end of string
      if (item_i.is_last && !fail_n && (ph_n != PhasePlain)) begin
        fail_n = 1'b1;
      end
    end
  end

  always_comb begin
    phase_d     = phase_q;
    nib_d       = nib_q;
    failed_d    = failed_q;
    out_valid_d = out_valid_q;
    res_d       = res_q;
    if (ready_o) begin
      out_valid_d = valid_i;
    end
    if (adv) begin
      res_d.byte_out     = byte_n;
      res_d.byte_valid   = bvalid_n;
      res_d.string_end   = item_i.is_last;
      res_d.decode_error = fail_n;
      if (item_i.is_last) begin
        phase_d  = PhasePlain;
        nib_d    = '0;
        failed_d = 1'b0;
      end else begin
        phase_d  = ph_n;
        nib_d    = nib_n;
        failed_d = fail_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhasePlain;
      nib_q       <= '0;
      failed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      nib_q       <= nib_d;
      failed_q    <= failed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o  = out_valid_q;
  assign result_o = res_q;

endmodule

`default_nettype wire

// ----- rtl/percent_decoder.sv -----
// a character passes through the input register and then the result register before its
// result is shown at the output
// throughput: one character per cycle, set by the input register and result register
// handing over in the same cycle while the output side takes transfers
// reset: rst_ni asynchronous active low, clears both valid flags and the escape
// state; the block starts in plain-character phase with no error pending
`timescale 1ns / 1ps
`default_nettype none

module percent_decoder (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  pctd_in_if.sink   in_i,
  pctd_out_if.source out_o
);

  pctd_pkg::item_t   in_item;
  pctd_pkg::item_t   s1_item;
  pctd_pkg::result_t res;
  logic              s1_valid;
  logic              s1_ready;

  assign in_item.char_in = in_i.char_in;
  assign in_item.is_last = in_i.is_last;

  pctd_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .item_i  (in_item),
    .valid_o (s1_valid),
    .ready_i (s1_ready),
    .item_o  (s1_item)
  );

  pctd_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s1_valid),
    .ready_o  (s1_ready),
    .item_i   (s1_item),
    .valid_o  (out_o.valid),
    .ready_i  (out_o.ready),
    .result_o (res)
  );

  assign out_o.byte_out     = res.byte_out;
  assign out_o.byte_valid   = res.byte_valid;
  assign out_o.string_end   = res.string_end;
  assign out_o.decode_error = res.decode_error;

endmodule

`default_nettype wire

// ----- rtl/pctd_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pctd_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] byte_out,
  input wire logic       byte_valid,
  input wire logic       string_end,
  input wire logic       decode_error
);

  // no result shown while in reset
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !out_valid)
    else $error("result valid during reset");

  // a result without a byte carries a zero byte
  a_zero_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !byte_valid) |-> (byte_out == 8'd0))
    else $error("nonzero byte without byte_valid");

  // a decoded byte never comes with the error flag
  a_no_byte_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && byte_valid) |-> !decode_error)
    else $error("byte emitted with decode_error set");

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(byte_out) && $stable(byte_valid) &&
       $stable(string_end) && $stable(decode_error)))
    else $error("stalled result changed");

  // an input transfer with no output pending is always taken by the pipe
  a_accept_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && !out_valid) |-> in_ready)
    else $error("input stalled with empty output");

endmodule

bind percent_decoder pctd_checker u_pctd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid     (in_i.valid),
  .in_ready     (in_i.ready),
  .out_valid    (out_o.valid),
  .out_ready    (out_o.ready),
  .byte_out     (out_o.byte_out),
  .byte_valid   (out_o.byte_valid),
  .string_end   (out_o.string_end),
  .decode_error (out_o.decode_error)
);

`default_nettype wire

// ----- bench/tb_percent_decoder.sv -----
`timescale 1ns / 1ps

module tb_percent_decoder;

  localparam int unsigned TargetChars = 1450;
  localparam int unsigned StallLimit  = 4000;
  localparam int unsigned IdlePct     = 8;
  localparam int unsigned MaxReports  = 10;

  typedef enum logic [1:0] {PhPlain, PhFirst, PhSecond} esc_phase_e;

  // escape state machine mirror plus the queue of decoded results still owed
  class decode_scoreboard;
    esc_phase_e          phase    = PhPlain;
    logic [3:0]          hi_nib   = '0;
    bit                  failed   = 1'b0;
    pctd_pkg::result_t   owed_q[$];
    int unsigned         mismatches = 0;

    function bit is_plain(logic [7:0] c);
      return (c >= pctd_pkg::Char0 && c <= pctd_pkg::Char9) ||
             (c >= pctd_pkg::CharUpA && c <= pctd_pkg::CharUpZ) ||
             (c >= pctd_pkg::CharLoA && c <= pctd_pkg::CharLoZ) ||
             c == pctd_pkg::CharDash || c == pctd_pkg::CharDot ||
             c == pctd_pkg::CharUnder || c == pctd_pkg::CharTilde;
    endfunction

    // bit 4 set means not an upper-case hex digit
    function logic [4:0] hex_digit(logic [7:0] c);
      if (c >= pctd_pkg::Char0 && c <= pctd_pkg::Char9) begin
        return {1'b0, c[3:0]};
      end
      if (c >= pctd_pkg::CharUpA && c <= pctd_pkg::CharUpF) begin
        return {1'b0, 4'(c[3:0] + 4'd9)};
      end
      return 5'h10;
    endfunction

    function void note_char(logic [7:0] c, logic last);
      pctd_pkg::result_t r;
      logic [4:0]        v;
      r = '0;
      if (!failed) begin
        case (phase)
          PhFirst: begin
            v = hex_digit(c);
            if (!v[4]) begin
              hi_nib = v[3:0];
              phase  = PhSecond;
            end else begin
              failed = 1'b1;
            end
          end
          PhSecond: begin
            v = hex_digit(c);
            if (!v[4]) begin
              r.byte_out   = {hi_nib, v[3:0]};
              r.byte_valid = 1'b1;
              phase        = PhPlain;
            end else begin
              failed = 1'b1;
            end
          end
          default: begin
            phase = PhPlain;
            if (is_plain(c)) begin
              r.byte_out   = c;
              r.byte_valid = 1'b1;
            end else if (c == pctd_pkg::CharPercent) begin
              phase = PhFirst;
            end else begin
              failed = 1'b1;
            end
          end
        endcase
        // escape cut off by the end of the string
        if (last && !failed && phase != PhPlain) failed = 1'b1;
      end
      r.string_end   = last;
      r.decode_error = failed;
      owed_q.insert(owed_q.size(), r);
      if (last) begin
        phase  = PhPlain;
        hi_nib = '0;
        failed = 1'b0;
      end
    endfunction

    function void check_result(pctd_pkg::result_t got);
      pctd_pkg::result_t exp;
      if (owed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("unexpected transfer: byte=%h bv=%b end=%b err=%b",
                   got.byte_out, got.byte_valid, got.string_end, got.decode_error);
        return;
      end
      exp = owed_q.pop_front();
      if (got.byte_out !== exp.byte_out || got.byte_valid !== exp.byte_valid ||
          got.string_end !== exp.string_end || got.decode_error !== exp.decode_error) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("mismatch: exp byte=%h bv=%b end=%b err=%b, got byte=%h bv=%b end=%b err=%b",
                   exp.byte_out, exp.byte_valid, exp.string_end, exp.decode_error,
                   got.byte_out, got.byte_valid, got.string_end, got.decode_error);
      end
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   quiet;
  int unsigned chars_sent;
  int unsigned stall_cycles;
  logic [7:0] text_q[$];
  decode_scoreboard sb = new;

  pctd_in_if  in_bus ();
  pctd_out_if out_bus ();

  percent_decoder dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result side: random stalls, sampled at the rising edge
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_bus.ready <= quiet || ($urandom_range(99) >= IdlePct);
    end
  end

  always @(posedge clk) begin
    pctd_pkg::result_t got;
    if (rst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      got.byte_out     = out_bus.byte_out;
      got.byte_valid   = out_bus.byte_valid;
      got.string_end   = out_bus.string_end;
      got.decode_error = out_bus.decode_error;
      sb.check_result(got);
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if ((in_bus.valid === 1'b1 && in_bus.ready === 1'b1) ||
        (out_bus.valid === 1'b1 && out_bus.ready === 1'b1)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_char(input logic [7:0] c, input logic last);
    while (!quiet && $urandom_range(99) < IdlePct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid   <= 1'b1;
    in_bus.char_in <= c;
    in_bus.is_last <= last;
    @(posedge clk);
    while (in_bus.ready !== 1'b1) @(posedge clk);
    sb.note_char(c, last);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_queued();
    int unsigned n;
    n = text_q.size();
    for (int unsigned i = 0; i < n; i++) send_char(text_q[i], i == n - 1);
    text_q.delete();
    quiet = (chars_sent >= 500 && chars_sent < 900);
  endtask

  task automatic add_char(input logic [7:0] c);
    text_q.insert(text_q.size(), c);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endtask

  task automatic drain_results();
    in_bus.valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  function automatic logic [7:0] rand_plain();
    case ($urandom_range(3))
      0: return 8'(pctd_pkg::Char0 + $urandom_range(9));
      1: return 8'(pctd_pkg::CharUpA + $urandom_range(25));
      2: return 8'(pctd_pkg::CharLoA + $urandom_range(25));
      default: begin
        case ($urandom_range(3))
          0: return pctd_pkg::CharDash;
          1: return pctd_pkg::CharDot;
          2: return pctd_pkg::CharUnder;
          default: return pctd_pkg::CharTilde;
        endcase
      end
    endcase
  endfunction

  function automatic logic [7:0] rand_hex();
    int unsigned n;
    n = $urandom_range(15);
    return (n < 10) ? 8'(pctd_pkg::Char0 + n) : 8'(pctd_pkg::CharUpA + n - 10);
  endfunction

  task automatic build_string();
    int unsigned tokens;
    int unsigned k;
    tokens = $urandom_range(1, 10);
    for (int unsigned t = 0; t < tokens; t++) begin
      k = $urandom_range(99);
      if (k < 55) begin
        add_char(rand_plain());
      end else if (k < 85) begin
        add_char(pctd_pkg::CharPercent);
        add_char(rand_hex());
        add_char(rand_hex());
      end else if (k < 89) begin
        // lower-case digit inside an escape
        add_char(pctd_pkg::CharPercent);
        if ($urandom_range(1)) add_char(rand_hex());
        add_char(8'(pctd_pkg::CharLoA + $urandom_range(5)));
      end else if (k < 94) begin
        add_char(8'($urandom_range(255)));
      end else begin
        add_char(pctd_pkg::CharPercent);
        add_char(rand_hex());
        add_char(8'($urandom_range(255)));
      end
    end
    // escape cut off by the end of the string
    if ($urandom_range(99) < 6) begin
      add_char(pctd_pkg::CharPercent);
      if ($urandom_range(1)) add_char(rand_hex());
    end
  endtask

  initial begin
    bit drained_once;
    drained_once   = 1'b0;
    quiet          = 1'b0;
    chars_sent     = 0;
    stall_cycles   = 0;
    in_bus.valid   = 1'b0;
    in_bus.char_in = '0;
    in_bus.is_last = 1'b0;
    rst_n          = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    push_text("0zA-._~");
    send_queued();
    push_text("%FF");
    send_queued();
    push_text("%00");
    send_queued();
    push_text("%4f");
    send_queued();
    add_char(8'h00);
    push_text("a");
    send_queued();
    push_text("%");
    send_queued();
    push_text("%A");
    send_queued();
    add_char(8'hFF);
    send_queued();
    drain_results();

    while (chars_sent < TargetChars) begin
      build_string();
      send_queued();
      if (!drained_once && chars_sent >= 1000) begin
        drained_once = 1'b1;
        drain_results();
      end
    end

    drain_results();
    repeat (4) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/pctd_pkg.sv
rtl/pctd_in_if.sv
rtl/pctd_out_if.sv
rtl/pctd_in_stage.sv
rtl/pctd_core.sv
rtl/percent_decoder.sv
rtl/pctd_checker.sv
bench/tb_percent_decoder.sv
